// ----- design/ltl_pkg.sv -----
// Shared types, character codes and character-class functions for the token lexer.
`timescale 1ns / 1ps
package ltl_pkg;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h27;
	localparam logic [7:0] CH_OPEN    = 8'h28;
	localparam logic [7:0] CH_CLOSE   = 8'h29;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_Z    = 8'h7A;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		K_CONST = 3'd0,
		K_SYM   = 3'd1,
		K_QUOTE = 3'd2,
		K_DOT   = 3'd3,
		K_OPEN  = 3'd4,
		K_CLOSE = 3'd5,
		K_END   = 3'd6,
		K_ERROR = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_NUM   = 2'd1,
		MODE_MINUS = 2'd2,
		MODE_SYM   = 2'd3
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] value;
		logic [7:0]         sym_char;
		logic               sym_first;
		logic               sym_last;
		logic               run_last;
	} res_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sym(logic [7:0] c);
		logic hit;
		hit = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
		case (c) inside
			8'h2B, 8'h2D, 8'h2E, 8'h2A, 8'h2F, 8'h3C, 8'h3D, 8'h3E, 8'h21,
			8'h3F, 8'h3A, 8'h24, 8'h25, 8'h5F, 8'h26, 8'h7E, 8'h5E: hit = 1'b1;
			default: ;
		endcase
		return hit;
	endfunction

endpackage

// ----- design/lisp_token_lexer_core.sv -----
// Top level of the streaming token lexer: character in, token words out.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  input   | in_valid / in_ready  | ch
//  output  | out_valid / out_ready| kind, value, sym_char, sym_first, sym_last, run_last
//
// One character is taken per cycle while in_ready is high; its words enter the result queue
// at the same edge and, if the queue was empty, the first one is offered in the next cycle.
// A character yields at most two words; the four-entry queue drains one word a cycle,
// so the output handshake sets the sustained rate.
// in_ready drops while fewer than two queue entries are free.
// Reset clears the lexer state, the error latch and the queue.
`timescale 1ns / 1ps
module lisp_token_lexer_core import ltl_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic signed [31:0] value,
	output logic [7:0]         sym_char,
	output logic               sym_first,
	output logic               sym_last,
	output logic               run_last
);

	logic       fire;
	logic [1:0] push_n;
	res_t       push0;
	res_t       push1;
	res_t       head;
	logic       room;

	assign in_ready = room;
	assign fire     = in_valid && room;

	ltl_lexer #(
		.VALUE_BITS(VALUE_BITS)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (ch),
		.push_n (push_n),
		.push0  (push0),
		.push1  (push1)
	);

	ltl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.push0  (push0),
		.push1  (push1),
		.pop    (out_ready),
		.head   (head),
		.valid  (out_valid),
		.room   (room)
	);

	assign kind      = head.kind;
	assign value     = head.value;
	assign sym_char  = head.sym_char;
	assign sym_first = head.sym_first;
	assign sym_last  = head.sym_last;
	assign run_last  = head.run_last;

	a_pair_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && push_n == 2'd2 |=> out_valid)
		else $error("two-word character left output empty");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_ERROR |-> run_last)
		else $error("error word not last of its character");

	a_sym_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sym_last || sym_first) |-> kind == K_SYM)
		else $error("symbol mark on non-symbol word");

endmodule

// ----- design/ltl_lexer.sv -----
// Lexer state registers and the per-character decode that yields up to two results.
`timescale 1ns / 1ps
module ltl_lexer import ltl_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] ch,
	output logic [1:0] push_n,
	output res_t       push0,
	output res_t       push1
);

	localparam int WIDE = VALUE_BITS + 4;
	localparam int EXT  = (VALUE_BITS > 32) ? VALUE_BITS : 32;

	mode_t                 mode_q, mode_d;
	logic [VALUE_BITS-1:0] mag_q, mag_d;
	logic                  neg_q, neg_d;
	logic [7:0]            held_q, held_d;
	logic                  held_first_q, held_first_d;
	logic                  err_q, err_d;

	logic [3:0]      digit;
	logic            c_digit;
	logic            c_sym;
	logic [WIDE-1:0] acc;
	logic [WIDE-1:0] lim;
	logic            over;
	logic [EXT-1:0]  mag_ext;
	logic [EXT-1:0]  sval;

	logic  f_has;
	kind_t f_kind;
	mode_t f_mode;
	logic  f_held;
	logic  f_num;
	logic  f_err;

	res_t  r0, r1;
	logic  take_fresh;
	logic  sym_path;
	logic [1:0] n;

	assign digit   = 4'(ch - CH_ZERO);
	assign c_digit = is_digit(ch);
	assign c_sym   = is_sym(ch);
	assign acc     = (WIDE'(mag_q) << 3) + (WIDE'(mag_q) << 1) + WIDE'(digit);
	assign lim     = (WIDE'(1) << (VALUE_BITS - 1)) - WIDE'(!neg_q);
	assign over    = acc > lim;
	assign mag_ext = EXT'(mag_q);
	assign sval    = neg_q ? (EXT'(0) - mag_ext) : mag_ext;

	always_comb begin
		f_has  = 1'b0;
		f_kind = K_END;
		f_mode = MODE_IDLE;
		f_held = 1'b0;
		f_num  = 1'b0;
		f_err  = 1'b0;
		unique case (ch) inside
			CH_SPACE, CH_NEWLINE: ;
			CH_NUL: begin
				f_has  = 1'b1;
				f_kind = K_END;
			end
			CH_QUOTE: begin
				f_has  = 1'b1;
				f_kind = K_QUOTE;
			end
			CH_DOT: begin
				f_has  = 1'b1;
				f_kind = K_DOT;
			end
			CH_OPEN: begin
				f_has  = 1'b1;
				f_kind = K_OPEN;
			end
			CH_CLOSE: begin
				f_has  = 1'b1;
				f_kind = K_CLOSE;
			end
			CH_MINUS: begin
				f_mode = MODE_MINUS;
				f_held = 1'b1;
			end
			default: begin
				if (c_digit) begin
					f_mode = MODE_NUM;
					f_num  = 1'b1;
				end else if (c_sym) begin
					f_mode = MODE_SYM;
					f_held = 1'b1;
				end else begin
					f_has  = 1'b1;
					f_kind = K_ERROR;
					f_err  = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		mode_d       = mode_q;
		mag_d        = mag_q;
		neg_d        = neg_q;
		held_d       = held_q;
		held_first_d = held_first_q;
		err_d        = err_q;
		r0           = '0;
		r1           = '0;
		n            = 2'd0;
		take_fresh   = 1'b0;
		sym_path     = 1'b0;

		if (fire && !err_q) begin
			unique case (mode_q)
				MODE_NUM: begin
					if (c_digit) begin
						if (over) begin
							err_d   = 1'b1;
							mode_d  = MODE_IDLE;
							r0.kind = K_ERROR;
							n       = 2'd1;
						end else begin
							mag_d = acc[VALUE_BITS-1:0];
						end
					end else begin
						r0.kind    = K_CONST;
						r0.value   = sval[31:0];
						n          = 2'd1;
						take_fresh = 1'b1;
					end
				end
				MODE_MINUS: begin
					if (c_digit) begin
						mode_d = MODE_NUM;
						neg_d  = 1'b1;
						mag_d  = VALUE_BITS'(digit);
					end else begin
						sym_path = 1'b1;
					end
				end
				MODE_SYM: sym_path = 1'b1;
				MODE_IDLE: take_fresh = 1'b1;
				default: ;
			endcase

			if (sym_path) begin
				r0.kind      = K_SYM;
				r0.sym_char  = held_q;
				r0.sym_first = held_first_q;
				n            = 2'd1;
				if (c_sym || c_digit) begin
					mode_d       = MODE_SYM;
					held_d       = ch;
					held_first_d = 1'b0;
				end else begin
					r0.sym_last = 1'b1;
					take_fresh  = 1'b1;
				end
			end

			if (take_fresh) begin
				mode_d = f_mode;
				if (f_held) begin
					held_d       = ch;
					held_first_d = 1'b1;
				end
				if (f_num) begin
					mag_d = VALUE_BITS'(digit);
					neg_d = 1'b0;
				end
				if (f_err) begin
					err_d = 1'b1;
				end
				if (f_has) begin
					if (n == 2'd0) begin
						r0.kind = f_kind;
					end else begin
						r1.kind = f_kind;
					end
					n = n + 2'd1;
				end
			end

			if (n == 2'd2) begin
				r1.run_last = 1'b1;
			end else if (n == 2'd1) begin
				r0.run_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			held_q       <= '0;
			held_first_q <= 1'b0;
			err_q        <= 1'b0;
		end else if (fire) begin
			mode_q       <= mode_d;
			mag_q        <= mag_d;
			neg_q        <= neg_d;
			held_q       <= held_d;
			held_first_q <= held_first_d;
			err_q        <= err_d;
		end
	end

	assign push_n = n;
	assign push0  = r0;
	assign push1  = r1;

endmodule

// ----- design/ltl_queue.sv -----
// Result queue: takes up to two words per cycle, hands out one.
`timescale 1ns / 1ps
module ltl_queue import ltl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       push0,
	input  res_t       push1,
	input  logic       pop,
	output res_t       head,
	output logic       valid,
	output logic       room
);

	res_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] wr_next;
	logic              do_pop;

	assign wr_next = wr_ptr_q + QPTR_W'(1);
	assign valid   = cnt_q != '0;
	assign room    = cnt_q <= QCNT_W'(QDEPTH - 2);
	assign head    = ent_q[rd_ptr_q];
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			ent_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			ent_q[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(do_pop);
		end
	end

endmodule

// ----- sim/token_checker.sv -----
// Token checker: tracks accepted characters, predicts the lexer's result words and compares them.
`timescale 1ns / 1ps
module token_checker import ltl_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         ch,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	input  logic [7:0]         sym_char,
	input  logic               sym_first,
	input  logic               sym_last,
	input  logic               run_last,
	output int                 failures,
	output int                 outstanding,
	output int                 chars_seen,
	output int                 words_seen
);

	mode_t       lex_state = MODE_IDLE;
	logic [63:0] accum = '0;
	logic        neg = 1'b0;
	logic [7:0]  held = '0;
	logic        held_first = 1'b0;
	logic        dead = 1'b0;
	res_t        step_words[$];
	res_t        pending_tokens[$];

	initial begin
		failures = 0;
		outstanding = 0;
		chars_seen = 0;
		words_seen = 0;
	end

	function automatic logic digit_char(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic symbol_char(logic [7:0] c);
		logic hit;
		hit = (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
		case (c)
			"+", "-", ".", "*", "/", "<", "=", ">", "!", "?", ":", "$", "%", "_", "&", "~",
			"^": hit = 1'b1;
			default: ;
		endcase
		return hit;
	endfunction

	task automatic put_word(kind_t k, logic [31:0] v, logic [7:0] s, logic f, logic l);
		res_t w;
		w.kind = k;
		w.value = v;
		w.sym_char = s;
		w.sym_first = f;
		w.sym_last = l;
		w.run_last = 1'b0;
		step_words.push_back(w);
	endtask

	task automatic open_token(logic [7:0] c);
		lex_state = MODE_IDLE;
		case (c)
			CH_SPACE, CH_NEWLINE: ;
			CH_NUL:   put_word(K_END, '0, '0, 1'b0, 1'b0);
			CH_QUOTE: put_word(K_QUOTE, '0, '0, 1'b0, 1'b0);
			CH_DOT:   put_word(K_DOT, '0, '0, 1'b0, 1'b0);
			CH_OPEN:  put_word(K_OPEN, '0, '0, 1'b0, 1'b0);
			CH_CLOSE: put_word(K_CLOSE, '0, '0, 1'b0, 1'b0);
			CH_MINUS: begin
				lex_state = MODE_MINUS;
				held = c;
				held_first = 1'b1;
			end
			default: begin
				if (digit_char(c)) begin
					lex_state = MODE_NUM;
					accum = 64'(c) - 64'(CH_ZERO);
					neg = 1'b0;
				end else if (symbol_char(c)) begin
					lex_state = MODE_SYM;
					held = c;
					held_first = 1'b1;
				end else begin
					dead = 1'b1;
					put_word(K_ERROR, '0, '0, 1'b0, 1'b0);
				end
			end
		endcase
	endtask

	task automatic lex_char(logic [7:0] c);
		logic [63:0] d;
		logic [63:0] lim;
		logic [63:0] v;
		res_t w;
		step_words.delete();
		d = 64'(c) - 64'(CH_ZERO);
		if (!dead) begin
			if (lex_state == MODE_NUM) begin
				if (digit_char(c)) begin
					lim = (64'd1 << (VALUE_BITS - 1)) - 64'd1 + 64'(neg);
					if (accum > (lim - d) / 64'd10) begin
						dead = 1'b1;
						lex_state = MODE_IDLE;
						put_word(K_ERROR, '0, '0, 1'b0, 1'b0);
					end else begin
						accum = accum * 64'd10 + d;
					end
				end else begin
					v = neg ? 64'd0 - accum : accum;
					put_word(K_CONST, v[31:0], '0, 1'b0, 1'b0);
					open_token(c);
				end
			end else if (lex_state == MODE_MINUS && digit_char(c)) begin
				lex_state = MODE_NUM;
				neg = 1'b1;
				accum = d;
			end else if (lex_state == MODE_MINUS || lex_state == MODE_SYM) begin
				lex_state = MODE_SYM;
				if (symbol_char(c) || digit_char(c)) begin
					put_word(K_SYM, '0, held, held_first, 1'b0);
					held = c;
					held_first = 1'b0;
				end else begin
					put_word(K_SYM, '0, held, held_first, 1'b1);
					open_token(c);
				end
			end else begin
				open_token(c);
			end
		end
		foreach (step_words[i]) begin
			w = step_words[i];
			w.run_last = (i == step_words.size() - 1);
			pending_tokens.push_back(w);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			failures++;
		end
	endtask

	always @(negedge clk) begin
		res_t w;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				chars_seen++;
				lex_char(ch);
			end
			if (out_valid && out_ready) begin
				words_seen++;
				if (pending_tokens.size() == 0) begin
					$error("word of kind %0d arrived with nothing expected", kind);
					failures++;
				end else begin
					w = pending_tokens.pop_front();
					check_field("kind", 32'(w.kind), 32'(kind));
					check_field("value", w.value, value);
					check_field("sym_char", 32'(w.sym_char), 32'(sym_char));
					check_field("sym_first", 32'(w.sym_first), 32'(sym_first));
					check_field("sym_last", 32'(w.sym_last), 32'(sym_last));
					check_field("run_last", 32'(w.run_last), 32'(run_last));
				end
			end
			outstanding = pending_tokens.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Testbench top: feeds character streams to the token lexer and reports the verdict.
`timescale 1ns / 1ps
module testbench;
	import ltl_pkg::*;

	localparam int VALUE_BITS = 32;
	localparam int RANDOM_CHARS = 1300;
	localparam int SQUEEZE_AT = 400;
	localparam int LONG_HOLD = 60;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         ch = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         kind;
	logic signed [31:0] value;
	logic [7:0]         sym_char;
	logic               sym_first;
	logic               sym_last;
	logic               run_last;

	int   failures;
	int   outstanding;
	int   chars_seen;
	int   words_seen;
	int   sent = 0;
	logic calm = 1'b0;
	logic squeeze = 1'b0;
	logic gappy = 1'b1;
	logic overflow_end = 1'b0;

	string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
	string signs = "+-*/<=>!?:$%_&~^";
	string digits = "0123456789";
	string breaks = " \n()'";
	string puncts = "'.()";
	string noise = "aZq+-.*/<=>!?:$%_&~^0123456789 \n'()";
	string strays = "\t#\",;@[]{}|\\";

	lisp_token_lexer_core #(.VALUE_BITS(VALUE_BITS)) dut (
		.clk, .arst_n, .in_valid, .in_ready, .ch, .out_valid, .out_ready,
		.kind, .value, .sym_char, .sym_first, .sym_last, .run_last
	);

	token_checker #(.VALUE_BITS(VALUE_BITS)) token_check (
		.clk, .arst_n, .in_valid, .in_ready, .ch, .out_valid, .out_ready,
		.kind, .value, .sym_char, .sym_first, .sym_last, .run_last,
		.failures, .outstanding, .chars_seen, .words_seen
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	task automatic send(logic [7:0] c);
		if (gappy && !calm && $urandom_range(9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i]);
	endtask

	task automatic send_number();
		logic [31:0] mag;
		logic        minus;
		minus = 1'($urandom_range(1));
		case ($urandom_range(9))
			0, 1, 2, 3, 4: mag = $urandom_range(0, 99);
			5, 6:          mag = $urandom_range(0, 99999);
			7:             mag = minus ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default:       mag = $urandom_range(0, 32'h7FFF_FFFF);
		endcase
		if (minus)
			send(CH_MINUS);
		if ($urandom_range(7) == 0)
			send(CH_ZERO);
		send_text($sformatf("%0d", mag));
	endtask

	task automatic send_symbol();
		send($urandom_range(1) ? pick(letters) : pick(signs));
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(3))
				0: send(pick(letters));
				1: send(pick(signs));
				2: send(pick(digits));
				default: send(CH_DOT);
			endcase
		end
	endtask

	task automatic send_chunk();
		gappy = $urandom_range(2) != 0;
		case ($urandom_range(11))
			0, 1, 2, 3: send_symbol();
			4, 5, 6:    send_number();
			7: begin
				send_number();
				send(pick(letters));
			end
			8:  send(pick(puncts));
			9:  repeat ($urandom_range(1, 8)) send(pick(noise));
			10: send(CH_NUL);
			default: ;
		endcase
		send($urandom_range(15) == 0 ? CH_NUL : pick(breaks));
	endtask

	initial begin
		bit held_off;
		held_off = 1'b0;
		@(posedge clk);
		forever begin
			if (squeeze && !held_off) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		int base;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("2147483647 -2147483648(- -a 7x ab9)'.\nz");
		send(CH_NUL);

		base = sent;
		while (sent - base < RANDOM_CHARS) begin
			if (!squeeze && sent - base >= SQUEEZE_AT)
				squeeze = 1'b1;
			send_chunk();
		end

		// end the stream on an error, then show that nothing more comes out
		calm = 1'b1;
		overflow_end = 1'($urandom_range(1));
		send(CH_SPACE);
		if (overflow_end) begin
			if ($urandom_range(1) != 0)
				send_text("2147483648");
			else
				send_text("-2147483649");
		end else begin
			send_text("ab");
			case ($urandom_range(2))
				0: send(8'($urandom_range(128, 255)));
				1: send(pick(strays));
				default: send(8'($urandom_range(1, 8)));
			endcase
		end
		send(8'hFF);
		send(CH_NUL);
		repeat (30) send(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		for (int i = 0; i < 4000 && outstanding != 0; i++)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (outstanding != 0)
			$error("%0d expected words never arrived", outstanding);
		$display("lexed %0d characters of random token streams with a %0d-cycle output hold-off",
			chars_seen, LONG_HOLD);
		$display("checked %0d result words; stream closed by %s, later input ignored",
			words_seen, overflow_end ? "a constant overflow" : "an unknown byte");
		if (failures == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ltl_pkg.sv
design/ltl_lexer.sv
design/ltl_queue.sv
design/lisp_token_lexer_core.sv
sim/token_checker.sv
sim/testbench.sv
